>>> rtl/core/sm4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM4 cipher engine package
// Shared types, register codes and constant tables of the SM4 engine.
// ----------------------------------------------------------------------------
package sm4_pkg;

  localparam int unsigned AddrW = 6;
  localparam int unsigned DataW = 64;

  typedef enum logic [2:0] {
    REG_KEY_HIGH     = 3'd0,
    REG_KEY_LOW      = 3'd1,
    REG_IV_HIGH      = 3'd2,
    REG_IV_LOW       = 3'd3,
    REG_DECRYPT_MODE = 3'd4,
    REG_CHAIN_MODE   = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_PREFETCH,
    ST_ROUND,
    ST_FINISH
  } ctl_state_e;

  typedef struct packed {
    logic capture;
    logic load_key;
    logic load_blk;
    logic key_round;
    logic cipher_round;
    logic finish;
  } sm4_cmd_t;

  localparam logic [31:0] FK0 = 32'hA3B1BAC6;
  localparam logic [31:0] FK1 = 32'h56AA3350;
  localparam logic [31:0] FK2 = 32'h677D9197;
  localparam logic [31:0] FK3 = 32'hB27022DC;

  localparam logic [7:0] SBOX [0:255] = '{
    8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
    8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
    8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
    8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
    8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
    8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
    8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
    8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
    8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
    8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
    8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
    8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
    8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
    8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
    8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
  };

  // Byte j of CK word i is (4i + j) * 7 modulo 256.
  function automatic logic [31:0] ck_word(input logic [7:0] idx);
    logic [31:0] w;
    logic [9:0]  b;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      b = (10'({idx, 2'b00}) + 10'(j)) * 10'd7;
      w = {w[23:0], b[7:0]};
    end
    return w;
  endfunction

  function automatic logic [31:0] tau(input logic [31:0] a);
    return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
  endfunction

endpackage

>>> rtl/core/sm4_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM4 generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module sm4_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32,
  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/sm4_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM4 datapath
// Shared round unit for key expansion and cipher rounds, round key memory,
// chaining value and result register.
// ----------------------------------------------------------------------------
module sm4_datapath #(
  parameter int unsigned Rounds = 32,
  localparam int unsigned RndW  = $clog2(Rounds)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sm4_pkg::sm4_cmd_t cmd_i,
  input  logic [RndW-1:0]   rnd_i,
  input  logic [RndW-1:0]   rd_addr_i,
  input  logic [63:0]       key_high_i,
  input  logic [63:0]       key_low_i,
  input  logic [63:0]       iv_high_i,
  input  logic [63:0]       iv_low_i,
  input  logic              decrypt_i,
  input  logic              chain_i,
  input  logic [63:0]       block_high_i,
  input  logic [63:0]       block_low_i,
  input  logic              restart_chain_i,
  output logic [63:0]       result_high_o,
  output logic [63:0]       result_low_o
);

  logic [31:0]  x_q [4];
  logic [31:0]  x_d [4];
  logic [127:0] blk_q;
  logic [127:0] chain_q;
  logic [127:0] chain_d;
  logic [127:0] res_q;
  logic [127:0] src;
  logic [127:0] chain_eff;
  logic [127:0] mask;
  logic [127:0] res;
  logic [31:0]  rk;
  logic [31:0]  op;
  logic [31:0]  s;
  logic [31:0]  t_key;
  logic [31:0]  t_enc;

  sm4_ram #(
    .Width(32),
    .Depth(Rounds)
  ) u_rk_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.key_round),
    .waddr_i(rnd_i),
    .wdata_i(t_key),
    .raddr_i(rd_addr_i),
    .rdata_o(rk)
  );

  always_comb begin
    op    = cmd_i.key_round ? sm4_pkg::ck_word(8'(rnd_i)) : rk;
    s     = sm4_pkg::tau(x_q[1] ^ x_q[2] ^ x_q[3] ^ op);
    t_key = x_q[0] ^ s ^ {s[18:0], s[31:19]} ^ {s[8:0], s[31:9]};
    t_enc = x_q[0] ^ s ^ {s[29:0], s[31:30]} ^ {s[21:0], s[31:22]}
          ^ {s[13:0], s[31:14]} ^ {s[7:0], s[31:8]};
  end

  always_comb begin
    src       = cmd_i.capture ? {block_high_i, block_low_i} : blk_q;
    chain_eff = (cmd_i.capture && restart_chain_i) ? {iv_high_i, iv_low_i} : chain_q;
    mask      = (chain_i && !decrypt_i) ? chain_eff : '0;
    res       = {x_q[3], x_q[2], x_q[1], x_q[0]}
              ^ ((chain_i && decrypt_i) ? chain_q : 128'd0);
  end

  always_comb begin
    x_d = x_q;
    if (cmd_i.load_key) begin
      x_d[0] = key_high_i[63:32] ^ sm4_pkg::FK0;
      x_d[1] = key_high_i[31:0] ^ sm4_pkg::FK1;
      x_d[2] = key_low_i[63:32] ^ sm4_pkg::FK2;
      x_d[3] = key_low_i[31:0] ^ sm4_pkg::FK3;
    end else if (cmd_i.load_blk) begin
      x_d[0] = src[127:96] ^ mask[127:96];
      x_d[1] = src[95:64] ^ mask[95:64];
      x_d[2] = src[63:32] ^ mask[63:32];
      x_d[3] = src[31:0] ^ mask[31:0];
    end else if (cmd_i.key_round || cmd_i.cipher_round) begin
      x_d[0] = x_q[1];
      x_d[1] = x_q[2];
      x_d[2] = x_q[3];
      x_d[3] = cmd_i.key_round ? t_key : t_enc;
    end
  end

  always_comb begin
    chain_d = chain_q;
    if (cmd_i.capture) begin
      chain_d = chain_eff;
    end else if (cmd_i.finish && chain_i) begin
      chain_d = decrypt_i ? blk_q : res;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    if (cmd_i.capture) begin
      blk_q <= {block_high_i, block_low_i};
    end
    if (cmd_i.finish) begin
      res_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= '0;
    end else begin
      chain_q <= chain_d;
    end
  end

  assign result_high_o = res_q[127:64];
  assign result_low_o  = res_q[63:0];

endmodule

>>> rtl/core/sm4_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM4 controller
// Sequences key expansion, the cipher rounds and the hand-over of each result.
// ----------------------------------------------------------------------------
module sm4_ctrl #(
  parameter int unsigned Rounds = 32,
  localparam int unsigned RndW  = $clog2(Rounds)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic              key_wr_i,
  input  logic              decrypt_i,
  output sm4_pkg::sm4_cmd_t cmd_o,
  output logic [RndW-1:0]   rnd_o,
  output logic [RndW-1:0]   rd_addr_o
);

  localparam logic [RndW-1:0] LastIdx = RndW'(Rounds - 1);

  sm4_pkg::ctl_state_e state_q, state_d;
  logic [RndW-1:0]     rnd_q, rnd_d;
  logic                keys_ready_q, keys_ready_d;
  logic                out_valid_q, out_valid_d;
  logic [RndW-1:0]     rd_idx;
  logic                last_rnd;
  logic                out_free;

  assign last_rnd  = (rnd_q == LastIdx);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign rd_addr_o = decrypt_i ? (LastIdx - rd_idx) : rd_idx;
  assign rnd_o     = rnd_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      sm4_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = keys_ready_q ? sm4_pkg::ST_ROUND : sm4_pkg::ST_EXPAND;
        end
      end
      sm4_pkg::ST_EXPAND: begin
        if (last_rnd) begin
          state_d = sm4_pkg::ST_PREFETCH;
        end
      end
      sm4_pkg::ST_PREFETCH: state_d = sm4_pkg::ST_ROUND;
      sm4_pkg::ST_ROUND: begin
        if (last_rnd) begin
          state_d = sm4_pkg::ST_FINISH;
        end
      end
      sm4_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = sm4_pkg::ST_IDLE;
        end
      end
      default: state_d = sm4_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    in_stall_o   = 1'b1;
    rd_idx       = '0;
    rnd_d        = rnd_q;
    keys_ready_d = keys_ready_q;
    out_valid_d  = out_valid_q && out_stall_i;
    case (state_q)
      sm4_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        rnd_d      = '0;
        if (in_valid_i) begin
          cmd_o.capture  = 1'b1;
          cmd_o.load_key = !keys_ready_q;
          cmd_o.load_blk = keys_ready_q;
        end
      end
      sm4_pkg::ST_EXPAND: begin
        cmd_o.key_round = 1'b1;
        rnd_d           = rnd_q + 1'b1;
        if (last_rnd) begin
          keys_ready_d = 1'b1;
        end
      end
      sm4_pkg::ST_PREFETCH: begin
        cmd_o.load_blk = 1'b1;
        rnd_d          = '0;
      end
      sm4_pkg::ST_ROUND: begin
        cmd_o.cipher_round = 1'b1;
        rd_idx             = rnd_q + 1'b1;
        rnd_d              = rnd_q + 1'b1;
      end
      sm4_pkg::ST_FINISH: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
    if (key_wr_i) begin
      keys_ready_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sm4_pkg::ST_IDLE;
      rnd_q        <= '0;
      keys_ready_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rnd_q        <= rnd_d;
      keys_ready_q <= keys_ready_d;
      out_valid_q  <= out_valid_d;
    end
  end

  a_round_to_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sm4_pkg::ST_ROUND && last_rnd) |=> state_q == sm4_pkg::ST_FINISH)
    else $error("Last cipher round did not lead to the finish state.");

  a_keys_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sm4_pkg::ST_EXPAND && last_rnd && !key_wr_i) |=> keys_ready_q)
    else $error("Round keys not marked ready after expansion.");

  a_key_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_wr_i |=> !keys_ready_q)
    else $error("Key write did not invalidate the round keys.");

  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> (out_valid_q && state_q == sm4_pkg::ST_IDLE))
    else $error("Finished item was not presented on the output.");

endmodule

>>> rtl/core/sm4_block_cipher_ecb_cbc_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM4 block cipher engine, ECB and CBC
// Register file, controller and round datapath of the SM4-128 engine.
// ----------------------------------------------------------------------------
// With round keys ready an accepted item is loaded into the round state,
// runs its cipher rounds on the single round unit and is registered as the
// result. No new item is accepted until that result is registered, which
// waits while the output stalls. The first item after a key write first
// expands the key into the round key RAM. Reset clears control state, the
// registers and the chaining value, and marks the round keys as stale.
module sm4_block_cipher_ecb_cbc_top #(
  parameter int unsigned Rounds = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sm4_pkg::AddrW-1:0]  paddr,
  input  logic [sm4_pkg::DataW-1:0]  pwdata,
  output logic [sm4_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [63:0]                block_high_i,
  input  logic [63:0]                block_low_i,
  input  logic                       restart_chain_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [63:0]                result_high_o,
  output logic [63:0]                result_low_o
);

  localparam int unsigned RndW = $clog2(Rounds);

  logic [63:0]       key_high_q, key_low_q, iv_high_q, iv_low_q;
  logic              decrypt_q, chain_q;
  logic              wr_en;
  logic              key_wr;
  sm4_pkg::reg_idx_e reg_idx;
  sm4_pkg::sm4_cmd_t cmd;
  logic [RndW-1:0]   rnd;
  logic [RndW-1:0]   rd_addr;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = sm4_pkg::reg_idx_e'(paddr[5:3]);
  assign key_wr  = wr_en && (reg_idx == sm4_pkg::REG_KEY_HIGH ||
                             reg_idx == sm4_pkg::REG_KEY_LOW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      iv_high_q  <= '0;
      iv_low_q   <= '0;
      decrypt_q  <= 1'b0;
      chain_q    <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        sm4_pkg::REG_KEY_HIGH:     key_high_q <= pwdata;
        sm4_pkg::REG_KEY_LOW:      key_low_q  <= pwdata;
        sm4_pkg::REG_IV_HIGH:      iv_high_q  <= pwdata;
        sm4_pkg::REG_IV_LOW:       iv_low_q   <= pwdata;
        sm4_pkg::REG_DECRYPT_MODE: decrypt_q  <= pwdata[0];
        sm4_pkg::REG_CHAIN_MODE:   chain_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sm4_pkg::REG_KEY_HIGH:     prdata = key_high_q;
      sm4_pkg::REG_KEY_LOW:      prdata = key_low_q;
      sm4_pkg::REG_IV_HIGH:      prdata = iv_high_q;
      sm4_pkg::REG_IV_LOW:       prdata = iv_low_q;
      sm4_pkg::REG_DECRYPT_MODE: prdata = {63'd0, decrypt_q};
      sm4_pkg::REG_CHAIN_MODE:   prdata = {63'd0, chain_q};
      default:                   prdata = '0;
    endcase
  end

  sm4_ctrl #(
    .Rounds(Rounds)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .key_wr_i   (key_wr),
    .decrypt_i  (decrypt_q),
    .cmd_o      (cmd),
    .rnd_o      (rnd),
    .rd_addr_o  (rd_addr)
  );

  sm4_datapath #(
    .Rounds(Rounds)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .rnd_i          (rnd),
    .rd_addr_i      (rd_addr),
    .key_high_i     (key_high_q),
    .key_low_i      (key_low_q),
    .iv_high_i      (iv_high_q),
    .iv_low_i       (iv_low_q),
    .decrypt_i      (decrypt_q),
    .chain_i        (chain_q),
    .block_high_i   (block_high_i),
    .block_low_i    (block_low_i),
    .restart_chain_i(restart_chain_i),
    .result_high_o  (result_high_o),
    .result_low_o   (result_low_o)
  );

endmodule

>>> sim/sm4_block_cipher_ecb_cbc_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM4 block cipher engine testbench
// Sends 128-bit blocks through the engine under a series of key, IV and mode
// settings written over the register port. A predictor in the bench follows
// the key schedule, the rounds and the CBC chaining, and every result item is
// compared field by field with the expected block. Both sides idle at random.
// ----------------------------------------------------------------------------
module sm4_block_cipher_ecb_cbc_top_test;

  import sm4_pkg::*;

  localparam logic [2:0] REG_UNMAPPED = 3'd6;
  localparam int unsigned NumRounds = 32;
  localparam int unsigned RandPhases = 10;
  localparam int unsigned PhaseItems = 125;

  localparam logic [7:0] SM4_SBOX [256] = '{
    8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
    8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
    8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
    8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
    8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
    8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
    8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
    8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
    8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
    8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
    8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
    8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
    8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
    8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
    8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
  };

  localparam logic [31:0] SYS_FK [4] = '{32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC};

  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
  } sm4_block_t;

  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
    logic        restart;
    logic        drain_first;
  } pending_block_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [DataW-1:0]    pwdata = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [63:0]         blk_high = '0;
  logic [63:0]         blk_low = '0;
  logic                blk_restart = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [63:0]         res_high;
  logic [63:0]         res_low;

  // Predictor state.
  logic [63:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  logic        decrypt_q, cbc_q, keys_valid_q;
  logic [31:0] round_key_q [NumRounds];
  logic [63:0] chain_hi_q, chain_lo_q;

  pending_block_t pending_blocks[$];
  sm4_block_t     expected_blocks[$];

  int unsigned mismatches = 0;
  int unsigned blocks_in = 0;
  int unsigned blocks_out = 0;
  int unsigned settings_used = 0;
  int unsigned restarts_seen = 0;
  int unsigned mode_count [4] = '{0, 0, 0, 0};
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned sink_taken = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned stall_mode_left = 0;
  int unsigned stall_pct = 0;

  sm4_block_cipher_ecb_cbc_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .block_high_i    (blk_high),
    .block_low_i     (blk_low),
    .restart_chain_i (blk_restart),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .result_high_o   (res_high),
    .result_low_o    (res_low)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] a);
    return {SM4_SBOX[a[31:24]], SM4_SBOX[a[23:16]], SM4_SBOX[a[15:8]], SM4_SBOX[a[7:0]]};
  endfunction

  function automatic logic [31:0] ck_const(input int i);
    logic [31:0] w;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      w = {w[23:0], 8'(((4 * i + j) * 7) % 256)};
    end
    return w;
  endfunction

  function automatic void expand_round_keys();
    logic [31:0] k [4];
    logic [31:0] t;
    k[0] = key_hi_q[63:32] ^ SYS_FK[0];
    k[1] = key_hi_q[31:0] ^ SYS_FK[1];
    k[2] = key_lo_q[63:32] ^ SYS_FK[2];
    k[3] = key_lo_q[31:0] ^ SYS_FK[3];
    for (int i = 0; i < NumRounds; i++) begin
      t = sub_word(k[1] ^ k[2] ^ k[3] ^ ck_const(i));
      t = k[0] ^ t ^ rol32(t, 13) ^ rol32(t, 23);
      round_key_q[i] = t;
      k[0] = k[1];
      k[1] = k[2];
      k[2] = k[3];
      k[3] = t;
    end
    keys_valid_q = 1'b1;
  endfunction

  function automatic sm4_block_t sm4_rounds(input logic [63:0] hi, input logic [63:0] lo,
                                            input logic dec);
    logic [31:0] x [4];
    logic [31:0] t;
    x[0] = hi[63:32];
    x[1] = hi[31:0];
    x[2] = lo[63:32];
    x[3] = lo[31:0];
    for (int i = 0; i < NumRounds; i++) begin
      t = sub_word(x[1] ^ x[2] ^ x[3] ^ round_key_q[dec ? (NumRounds - 1 - i) : i]);
      t = x[0] ^ t ^ rol32(t, 2) ^ rol32(t, 10) ^ rol32(t, 18) ^ rol32(t, 24);
      x[0] = x[1];
      x[1] = x[2];
      x[2] = x[3];
      x[3] = t;
    end
    return {x[3], x[2], x[1], x[0]};
  endfunction

  function automatic sm4_block_t sm4_predict(input logic [63:0] hi, input logic [63:0] lo,
                                             input logic restart);
    sm4_block_t r;
    if (!keys_valid_q) expand_round_keys();
    if (restart) begin
      chain_hi_q = iv_hi_q;
      chain_lo_q = iv_lo_q;
      restarts_seen++;
    end
    mode_count[{decrypt_q, cbc_q}]++;
    if (!cbc_q) begin
      r = sm4_rounds(hi, lo, decrypt_q);
    end else if (decrypt_q) begin
      r = sm4_rounds(hi, lo, 1'b1);
      r.high ^= chain_hi_q;
      r.low ^= chain_lo_q;
      chain_hi_q = hi;
      chain_lo_q = lo;
    end else begin
      r = sm4_rounds(hi ^ chain_hi_q, lo ^ chain_lo_q, 1'b0);
      chain_hi_q = r.high;
      chain_lo_q = r.low;
    end
    return r;
  endfunction

  function automatic void clear_predictor();
    key_hi_q = '0;
    key_lo_q = '0;
    iv_hi_q = '0;
    iv_lo_q = '0;
    decrypt_q = 1'b0;
    cbc_q = 1'b0;
    keys_valid_q = 1'b0;
    chain_hi_q = '0;
    chain_lo_q = '0;
    for (int i = 0; i < NumRounds; i++) round_key_q[i] = '0;
  endfunction

  function automatic logic [63:0] rand_word();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom(), $urandom()};
  endfunction

  function automatic void push_block(input logic [63:0] hi, input logic [63:0] lo,
                                     input logic restart, input logic drain_first = 1'b0);
    pending_blocks.push_back('{high: hi, low: lo, restart: restart, drain_first: drain_first});
  endfunction

  function automatic void note_mismatch(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("Mismatch on %s at %0t: expected %h, got %h", what, $realtime, want, got);
    end
  endfunction

  task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_KEY_HIGH: begin
        key_hi_q = value;
        keys_valid_q = 1'b0;
      end
      REG_KEY_LOW: begin
        key_lo_q = value;
        keys_valid_q = 1'b0;
      end
      REG_IV_HIGH: iv_hi_q = value;
      REG_IV_LOW: iv_lo_q = value;
      REG_DECRYPT_MODE: decrypt_q = value[0];
      REG_CHAIN_MODE: cbc_q = value[0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_blocks.size() != 0 || in_valid || expected_blocks.size() != 0);
    repeat (2) @(posedge clk_i);
    settings_used++;
  endtask

  always @(posedge clk_i) begin : feed_blocks
    logic           busy;
    pending_block_t nxt;
    if (rst_ni) begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        expected_blocks.push_back(sm4_predict(blk_high, blk_low, blk_restart));
        blocks_in++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_blocks.size() != 0 &&
                     !(pending_blocks[0].drain_first && expected_blocks.size() != 0)) begin
          nxt = pending_blocks.pop_front();
          in_valid <= 1'b1;
          blk_high <= nxt.high;
          blk_low <= nxt.low;
          blk_restart <= nxt.restart;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : sink_stall
    if (rst_ni) begin
      if (out_valid && !out_stall) sink_taken++;
      if (!hold_done && sink_taken == 300) begin
        hold_done = 1'b1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (stall_mode_left == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 60;
            default: stall_pct = 90;
          endcase
          stall_mode_left = $urandom_range(16, 160);
        end else begin
          stall_mode_left--;
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    sm4_block_t want;
    if (rst_ni && out_valid && !out_stall) begin
      blocks_out++;
      if (expected_blocks.size() == 0) begin
        note_mismatch("unexpected result_high", '0, res_high);
      end else begin
        want = expected_blocks.pop_front();
        if (res_high !== want.high) note_mismatch("result_high", want.high, res_high);
        if (res_low !== want.low) note_mismatch("result_low", want.low, res_low);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still expected.", expected_blocks.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [63:0] mode_val;
    int unsigned drain_at;

    // Standard test vector to confirm the predictor itself.
    clear_predictor();
    key_hi_q = 64'h0123456789ABCDEF;
    key_lo_q = 64'hFEDCBA9876543210;
    expand_round_keys();
    if (sm4_rounds(key_hi_q, key_lo_q, 1'b0) !== {64'h681EDF34D206965E, 64'h86B3E94F536E4246})
    begin
      mismatches++;
      $display("Predictor fails the standard test vector.");
    end
    clear_predictor();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // CBC from the reset chaining value with the reset key.
    reg_write(REG_CHAIN_MODE, 64'hFFFF_FFFF_FFFF_FFF1);
    push_block('0, '0, 1'b0);
    push_block('1, '1, 1'b0);
    push_block('0, '0, 1'b1);
    wait_idle();

    // ECB encryption of the standard vector and extremes; a restart loads the IV.
    reg_write(REG_KEY_HIGH, 64'h0123456789ABCDEF);
    reg_write(REG_KEY_LOW, 64'hFEDCBA9876543210);
    reg_write(REG_IV_HIGH, 64'h0011223344556677);
    reg_write(REG_IV_LOW, 64'h8899AABBCCDDEEFF);
    reg_write(REG_CHAIN_MODE, 64'h2);
    push_block(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 1'b0);
    push_block('0, '0, 1'b0);
    push_block('1, '1, 1'b0);
    push_block(64'h8000_0000_0000_0000, 64'h1, 1'b0);
    push_block(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1);
    wait_idle();

    // CBC continues from the IV that the ECB restart loaded.
    reg_write(REG_CHAIN_MODE, 64'h1);
    push_block(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 1'b0);
    push_block(rand_word(), rand_word(), 1'b0);
    push_block(rand_word(), rand_word(), 1'b0);
    wait_idle();

    // A new IV has no effect until the next restart.
    reg_write(REG_IV_HIGH, '1);
    reg_write(REG_IV_LOW, '0);
    push_block(rand_word(), rand_word(), 1'b0);
    push_block(rand_word(), rand_word(), 1'b1);
    push_block(rand_word(), rand_word(), 1'b0);
    wait_idle();

    // CBC decryption, then a fresh low key half.
    reg_write(REG_DECRYPT_MODE, 64'h1);
    push_block(rand_word(), rand_word(), 1'b1);
    push_block('1, '0, 1'b0);
    wait_idle();
    reg_write(REG_KEY_LOW, rand_word());
    push_block(rand_word(), rand_word(), 1'b0);
    wait_idle();

    // ECB decryption of the standard ciphertext; unmapped write is ignored.
    reg_write(REG_KEY_LOW, 64'hFEDCBA9876543210);
    reg_write(REG_CHAIN_MODE, '0);
    reg_write(REG_UNMAPPED, '1);
    push_block(64'h681EDF34D206965E, 64'h86B3E94F536E4246, 1'b0);
    push_block('1, '1, 1'b0);
    wait_idle();

    // Only bit 0 of the mode registers counts.
    reg_write(REG_KEY_HIGH, '1);
    reg_write(REG_DECRYPT_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
    push_block('0, '1, 1'b0);
    push_block(rand_word(), rand_word(), 1'b0);

    for (int p = 0; p < RandPhases; p++) begin
      wait_idle();
      if (p == 0) begin
        reg_write(REG_KEY_HIGH, '0);
        reg_write(REG_KEY_LOW, '0);
      end else if (p == 1) begin
        reg_write(REG_KEY_HIGH, '1);
        reg_write(REG_KEY_LOW, '1);
        reg_write(REG_IV_HIGH, '1);
        reg_write(REG_IV_LOW, '1);
      end else begin
        if ($urandom_range(0, 1)) reg_write(REG_KEY_HIGH, rand_word());
        if ($urandom_range(0, 1)) reg_write(REG_KEY_LOW, rand_word());
        if ($urandom_range(0, 1)) reg_write(REG_IV_HIGH, rand_word());
        if ($urandom_range(0, 1)) reg_write(REG_IV_LOW, rand_word());
      end
      mode_val = {$urandom(), $urandom()};
      if (p < 4) mode_val[0] = p[1];
      reg_write(REG_DECRYPT_MODE, mode_val);
      mode_val = {$urandom(), $urandom()};
      if (p < 4) mode_val[0] = p[0];
      reg_write(REG_CHAIN_MODE, mode_val);
      drain_at = (p % 3 == 1) ? $urandom_range(20, PhaseItems - 20) : PhaseItems;
      for (int n = 0; n < PhaseItems; n++) begin
        push_block(rand_word(), rand_word(),
                   (n == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0),
                   n == drain_at);
      end
    end

    do @(negedge clk_i);
    while (pending_blocks.size() != 0 || in_valid || expected_blocks.size() != 0);
    repeat (80) @(posedge clk_i);
    mismatches += expected_blocks.size();

    $display("Run covered %0d blocks in, %0d results out, over %0d register settings.",
             blocks_in, blocks_out, settings_used);
    $display("ECB enc %0d, ECB dec %0d, CBC enc %0d, CBC dec %0d, chain restarts %0d.",
             mode_count[0], mode_count[2], mode_count[1], mode_count[3], restarts_seen);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches in total.", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sm4_block_cipher_ecb_cbc_top.f
rtl/core/sm4_pkg.sv
rtl/core/sm4_ram.sv
rtl/core/sm4_datapath.sv
rtl/core/sm4_ctrl.sv
rtl/core/sm4_block_cipher_ecb_cbc_top.sv
sim/sm4_block_cipher_ecb_cbc_top_test.sv
